@@ design/cbq_pkg.sv @@
// ----------------------------------------------------------------------------
// Cascaded biquad package
// Shared widths, operation codes, sequencer states and a helper function.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int COEF_W      = 32;
  localparam int DELAY_W     = 40;
  localparam int HALF_W      = 20;
  localparam int OPND_W      = HALF_W + 1;
  localparam int PROD_W      = COEF_W + OPND_W;
  localparam int FRAC_BITS   = 28;
  localparam int ACC_W       = 76;
  localparam int SHIFT_W     = ACC_W - FRAC_BITS;
  localparam int SECT_CFG_W  = 5;
  localparam int COEF_IDX_W  = 7;
  localparam int OP_W        = 2;
  localparam int SLOTS       = 5;
  localparam int DELAYS      = 2;

  localparam logic signed [SHIFT_W-1:0] DLY_MAX =
    SHIFT_W'((64'd1 << (DELAY_W - 1)) - 64'd1);
  localparam logic signed [SHIFT_W-1:0] DLY_MIN = ~DLY_MAX;

  typedef enum logic [OP_W-1:0] {
    OP_FILTER       = 2'd0,
    OP_CLEAR_FILTER = 2'd1,
    OP_WRITE_COEF   = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_W1,
    ST_RD_W2,
    ST_A1H,
    ST_A1L,
    ST_A2H,
    ST_A2L,
    ST_W_ACC,
    ST_W_FIN,
    ST_B0H,
    ST_B0L,
    ST_B1H,
    ST_B1L,
    ST_B2H,
    ST_B2L,
    ST_Y_ACC,
    ST_Y_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic hi_half;
    logic load;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [DELAY_W-1:0] value;
    logic                      clipped;
  } sat_t;

  function automatic sat_t clip_delay(input logic signed [SHIFT_W-1:0] v);
    sat_t r;
    r.value   = v[DELAY_W-1:0];
    r.clipped = 1'b0;
    if (v > DLY_MAX) begin
      r.value   = DLY_MAX[DELAY_W-1:0];
      r.clipped = 1'b1;
    end else if (v < DLY_MIN) begin
      r.value   = DLY_MIN[DELAY_W-1:0];
      r.clipped = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ design/cbq_in_if.sv @@
// ----------------------------------------------------------------------------
// Cascaded biquad input channel
// Valid/ready channel carrying one command beat: sample or coefficient write.
// ----------------------------------------------------------------------------
interface cbq_in_if
  import cbq_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [COEF_IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]      coef_value;

  modport source (output valid, operation, sample_in, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, operation, sample_in, coef_index, coef_value,
                  output ready);
endinterface

@@ design/cbq_out_if.sv @@
// ----------------------------------------------------------------------------
// Cascaded biquad output channel
// Valid/ready channel carrying one filtered sample beat.
// ----------------------------------------------------------------------------
interface cbq_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

@@ design/cbq_mac.sv @@
// ----------------------------------------------------------------------------
// Cascaded biquad multiply-accumulate unit
// One registered 32x21 signed multiplier feeding a wide accumulator.
// ----------------------------------------------------------------------------
module cbq_mac
  import cbq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic signed [OPND_W-1:0] opnd_i,
  input  logic signed [ACC_W-1:0]  init_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid_q;
  logic                     hi_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_q;

  assign prod_d   = coef_i * opnd_i;
  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign addend   = hi_q ? (prod_ext <<< HALF_W) : prod_ext;
  assign acc_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      hi_q   <= ctrl_i.hi_half;
    end
    if (ctrl_i.load) begin
      acc_q <= init_i;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + addend;
    end
  end

endmodule

@@ design/cascaded_biquad_iir_filter.sv @@
// A coefficient write or an unused operation gives no output beat. A sample
// beat runs the active sections in turn on the single multiplier, ten partial
// products per section, and no new beat is taken until its result is in the
// output register, which waits while an earlier result is not yet taken.
// Reset marks both stores empty (read as zero) at once and sets the section
// count to one; there is no clearing pass.
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter
// Direct form II second-order sections run in turn on one shared MAC unit.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter
  import cbq_pkg::*;
#(
  parameter int MAX_SECTIONS = 16,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SECT_CFG_W-1:0] cfg_wdata_i,
  cbq_in_if.sink                sample_i,
  cbq_out_if.source             result_o
);

  localparam int COEF_COUNT  = SLOTS * MAX_SECTIONS;
  localparam int DELAY_COUNT = DELAYS * MAX_SECTIONS;
  localparam int CAW         = $clog2(COEF_COUNT);
  localparam int DAW         = $clog2(DELAY_COUNT);
  localparam int CNTW        = $clog2(MAX_SECTIONS + 1);

  localparam logic signed [DELAY_W-1:0] OUT_MAX =
    DELAY_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [DELAY_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  state_e state_q, state_d;

  logic [SECT_CFG_W-1:0] sections_q;
  logic [CNTW-1:0]       eff_count;
  logic [CNTW-1:0]       count_q;
  logic [CNTW-1:0]       sec_q;
  logic [CNTW-1:0]       sec_next;
  logic [CAW-1:0]        caddr_q;
  logic [DAW-1:0]        daddr_q;

  logic signed [DELAY_W-1:0] x_q, w_q, w1_q, w2_q;
  logic                      sat_q;

  logic [COEF_W-1:0]      cmem [COEF_COUNT];
  logic [COEF_COUNT-1:0]  cvalid_q;
  logic [COEF_W-1:0]      crdata_q;
  logic                   crvalid_q;
  logic [CAW-1:0]         cwaddr;

  logic [DELAY_W-1:0]     dmem [DELAY_COUNT];
  logic [DELAY_COUNT-1:0] dvalid_q;
  logic [DELAY_W-1:0]     drdata_q;
  logic                   drvalid_q;
  logic [DAW-1:0]         d_addr;

  logic accept, start, clear, coef_wr;
  logic c_rd, d_rd, d_odd, d_wr, out_load, last_sec;

  mac_ctrl_t                 mac_ctrl;
  logic signed [DELAY_W-1:0] opnd_full;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [COEF_W-1:0]  coef;
  logic signed [ACC_W-1:0]   init;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   x_ext;
  logic signed [DELAY_W-1:0] dval;
  logic signed [DELAY_W-1:0] sample_ext;
  sat_t                      acc_sat;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic                          out_sat_q;
  logic                          out_clip;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept  = sample_i.valid & sample_i.ready;
  assign start   = accept && ((sample_i.operation == OP_FILTER) ||
                              (sample_i.operation == OP_CLEAR_FILTER));
  assign clear   = accept && (sample_i.operation == OP_CLEAR_FILTER);
  assign coef_wr = accept && (sample_i.operation == OP_WRITE_COEF) &&
                   (32'(sample_i.coef_index) < COEF_COUNT);
  assign cwaddr  = CAW'(sample_i.coef_index);

  assign eff_count = (32'(sections_q) > MAX_SECTIONS) ? CNTW'(MAX_SECTIONS)
                                                       : CNTW'(sections_q);
  assign sec_next  = sec_q + 1'b1;
  assign last_sec  = (sec_next == count_q);

  assign sample_ext = {{(DELAY_W - SAMPLE_BITS){sample_i.sample_in[SAMPLE_BITS-1]}},
                       sample_i.sample_in};
  assign x_ext   = {{(ACC_W - DELAY_W){x_q[DELAY_W-1]}}, x_q};
  assign dval    = drvalid_q ? $signed(drdata_q) : '0;
  assign coef    = crvalid_q ? $signed(crdata_q) : '0;
  assign opnd    = mac_ctrl.hi_half ? {opnd_full[DELAY_W-1], opnd_full[DELAY_W-1:HALF_W]}
                                    : {1'b0, opnd_full[HALF_W-1:0]};
  assign d_addr  = d_odd ? (daddr_q | DAW'(1)) : daddr_q;
  assign acc_sat = clip_delay(acc[ACC_W-1:FRAC_BITS]);

  always_comb begin
    out_clip     = 1'b0;
    out_sample_d = x_q[SAMPLE_BITS-1:0];
    if (x_q > OUT_MAX) begin
      out_clip     = 1'b1;
      out_sample_d = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (x_q < OUT_MIN) begin
      out_clip     = 1'b1;
      out_sample_d = OUT_MIN[SAMPLE_BITS-1:0];
    end
  end

  cbq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .opnd_i (opnd),
    .init_i (init),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mac_ctrl  = '0;
    opnd_full = '0;
    init      = ROUND_HALF;
    c_rd      = 1'b0;
    d_rd      = 1'b0;
    d_odd     = 1'b0;
    d_wr      = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (eff_count == '0) ? ST_OUT : ST_RD_W1;
        end
      end
      ST_RD_W1: begin
        d_rd    = 1'b1;
        c_rd    = 1'b1;
        state_d = ST_RD_W2;
      end
      ST_RD_W2: begin
        d_rd    = 1'b1;
        d_odd   = 1'b1;
        state_d = ST_A1H;
      end
      ST_A1H: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b1, load: 1'b1};
        opnd_full = w1_q;
        init      = (x_ext <<< FRAC_BITS) + ROUND_HALF;
        state_d   = ST_A1L;
      end
      ST_A1L: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b0, load: 1'b0};
        opnd_full = w1_q;
        c_rd      = 1'b1;
        state_d   = ST_A2H;
      end
      ST_A2H: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b1, load: 1'b0};
        opnd_full = w2_q;
        state_d   = ST_A2L;
      end
      ST_A2L: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b0, load: 1'b0};
        opnd_full = w2_q;
        c_rd      = 1'b1;
        state_d   = ST_W_ACC;
      end
      ST_W_ACC: begin
        state_d = ST_W_FIN;
      end
      ST_W_FIN: begin
        state_d = ST_B0H;
      end
      ST_B0H: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b1, load: 1'b1};
        opnd_full = w_q;
        state_d   = ST_B0L;
      end
      ST_B0L: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b0, load: 1'b0};
        opnd_full = w_q;
        c_rd      = 1'b1;
        state_d   = ST_B1H;
      end
      ST_B1H: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b1, load: 1'b0};
        opnd_full = w1_q;
        state_d   = ST_B1L;
      end
      ST_B1L: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b0, load: 1'b0};
        opnd_full = w1_q;
        c_rd      = 1'b1;
        state_d   = ST_B2H;
      end
      ST_B2H: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b1, load: 1'b0};
        opnd_full = w2_q;
        d_wr      = 1'b1;
        d_odd     = 1'b1;
        state_d   = ST_B2L;
      end
      ST_B2L: begin
        mac_ctrl  = '{mul_en: 1'b1, hi_half: 1'b0, load: 1'b0};
        opnd_full = w2_q;
        d_wr      = 1'b1;
        state_d   = ST_Y_ACC;
      end
      ST_Y_ACC: begin
        state_d = ST_Y_FIN;
      end
      ST_Y_FIN: begin
        state_d = last_sec ? ST_OUT : ST_RD_W1;
      end
      ST_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sections_q  <= SECT_CFG_W'(1);
      count_q     <= '0;
      sec_q       <= '0;
      caddr_q     <= '0;
      daddr_q     <= '0;
      cvalid_q    <= '0;
      dvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sections_q <= cfg_wdata_i;
      end
      if (start) begin
        count_q <= eff_count;
        sec_q   <= '0;
        caddr_q <= '0;
        daddr_q <= '0;
      end else begin
        if (c_rd) begin
          caddr_q <= caddr_q + 1'b1;
        end
        if (state_q == ST_Y_FIN) begin
          sec_q   <= sec_next;
          daddr_q <= daddr_q + DAW'(DELAYS);
        end
      end
      if (coef_wr) begin
        cvalid_q[cwaddr] <= 1'b1;
      end
      if (clear) begin
        dvalid_q <= '0;
      end else if (d_wr) begin
        dvalid_q[d_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_wr) begin
      cmem[cwaddr] <= sample_i.coef_value;
    end
    if (c_rd) begin
      crdata_q  <= cmem[caddr_q];
      crvalid_q <= cvalid_q[caddr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_wr) begin
      dmem[d_addr] <= d_odd ? w1_q : w_q;
    end
    if (d_rd) begin
      drdata_q  <= dmem[d_addr];
      drvalid_q <= dvalid_q[d_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q   <= sample_ext;
      sat_q <= 1'b0;
    end
    if (state_q == ST_RD_W2) begin
      w1_q <= dval;
    end
    if (state_q == ST_A1H) begin
      w2_q <= dval;
    end
    if (state_q == ST_W_FIN) begin
      w_q   <= acc_sat.value;
      sat_q <= sat_q | acc_sat.clipped;
    end
    if (state_q == ST_Y_FIN) begin
      x_q   <= acc_sat.value;
      sat_q <= sat_q | acc_sat.clipped;
    end
    if (out_load) begin
      out_sample_q <= out_sample_d;
      out_sat_q    <= sat_q | out_clip;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.sample_out = out_sample_q;
  assign result_o.saturated  = out_sat_q;

endmodule
